@@ src/ile_pkg.sv @@
package ile_pkg;

    // Operation codes carried by a request.
    typedef enum logic [2:0] {
        OP_READ     = 3'd0,
        OP_INS_HEAD = 3'd1,
        OP_INS_TAIL = 3'd2,
        OP_INS_AT   = 3'd3,
        OP_DELETE   = 3'd4
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    localparam int DATA_W  = 32;
    localparam int POS_W   = 16;
    localparam int COUNT_W = 7;

    // Command broadcast to every cell of the chain at once.
    typedef struct packed {
        logic              ins;  // insert val at pos, shift later cells up
        logic              del;  // remove cell at pos, shift later cells down
        logic              rd;   // drive the cell at pos onto the read bus
        logic [POS_W-1:0]  pos;  // target cell, unsigned
        logic [DATA_W-1:0] val;
    } t_cell_cmd;

endpackage

@@ src/ile_cell.sv @@
module ile_cell
    import ile_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  t_cell_cmd         i_cmd,
    input  logic [DATA_W-1:0] i_prev_val,
    input  logic [DATA_W-1:0] i_next_val,
    output logic [DATA_W-1:0] o_val,
    output logic [DATA_W-1:0] o_rd
);

    localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_cmd.ins) begin
            if (MY_POS > i_cmd.pos) begin
                n_val = i_prev_val;
            end else if (MY_POS == i_cmd.pos) begin
                n_val = i_cmd.val;
            end
        end else if (i_cmd.del && (MY_POS >= i_cmd.pos)) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_rd  = (i_cmd.rd && (MY_POS == i_cmd.pos)) ? r_val : '0;

endmodule

@@ src/indexed_list_engine.sv @@
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+----------------------------------------
// request   | in        | i_valid / o_ready  | i_opcode, i_position, i_item_value
// result    | out       | o_valid / i_ready  | o_read_value, o_status, o_element_count
//
// One request is taken per cycle while o_ready is high. Its result appears in
// the output register on the next cycle; the list itself is updated at the
// same edge that takes it. An insert or delete moves every later cell of the
// chain by one place at once, and a read selects across the CAPACITY cells.
// A new request is taken whenever the output register is empty or being drained.
// Reset (synchronous, active low) empties the list and the output register.
module indexed_list_engine
    import ile_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2:0]               i_opcode,
    input  logic signed [POS_W-1:0]  i_position,
    input  logic signed [DATA_W-1:0] i_item_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [1:0]               o_status,
    output logic [COUNT_W-1:0]       o_element_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    // Control state: element count and the output register's valid flag.
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_valid;
    logic              n_valid;

    // Result payload register.
    logic [DATA_W-1:0] r_rd;
    logic [DATA_W-1:0] n_rd;
    t_status           r_status;
    t_status           n_status;

    logic              accept;
    logic              full;
    logic              pos_neg;
    logic              pos_le_zero;
    logic [POS_W-1:0]  pos_u;
    logic [POS_W-1:0]  count_w;
    logic              in_range;
    t_cell_cmd         cmd;
    logic [DATA_W-1:0] rd_bus;

    logic [DATA_W-1:0] w_val [CAPACITY];
    logic [DATA_W-1:0] w_rd  [CAPACITY];

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign full        = (r_count == FULL_COUNT);
    assign pos_neg     = i_position[POS_W-1];
    assign pos_le_zero = pos_neg || (i_position == '0);
    assign pos_u       = {1'b0, i_position[POS_W-2:0]};
    assign count_w     = POS_W'(r_count);
    assign in_range    = !pos_neg && (pos_u < count_w);

    // Decode the request into a command for the cell chain and a status.
    // Commands only take effect on an accepted request.
    always_comb begin
        cmd      = '0;
        cmd.val  = i_item_value;
        n_status = ST_DONE;
        case (t_op'(i_opcode))
            OP_READ: begin
                cmd.pos = pos_u;
                if (in_range) begin
                    cmd.rd = 1'b1;
                end else begin
                    n_status = ST_BAD_POS;
                end
            end
            OP_INS_HEAD: begin
                cmd.pos = '0;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                end
            end
            OP_INS_TAIL: begin
                cmd.pos = count_w;
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                end
            end
            OP_INS_AT: begin
                // A position at or below zero means the head; a position above the
                // count is an error even when the list is full.
                cmd.pos = pos_le_zero ? '0 : pos_u;
                if (!pos_le_zero && (pos_u > count_w)) begin
                    n_status = ST_BAD_POS;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                end
            end
            OP_DELETE: begin
                cmd.pos = pos_u;
                if (in_range) begin
                    cmd.del = 1'b1;
                end else begin
                    n_status = ST_BAD_POS;
                end
            end
            default: begin
                n_status = ST_BAD_POS;
            end
        endcase
        cmd.ins = cmd.ins && accept;
        cmd.del = cmd.del && accept;
    end

    // The chain of cells: each cell holds one list element and trades values
    // with its neighbors on an insert or a delete.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] prev_val;
        logic [DATA_W-1:0] next_val;

        if (g == 0) begin : g_first
            assign prev_val = '0;
        end else begin : g_mid_prev
            assign prev_val = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_val = '0;
        end else begin : g_mid_next
            assign next_val = w_val[g+1];
        end

        ile_cell #(
            .INDEX(g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_cmd     (cmd),
            .i_prev_val(prev_val),
            .i_next_val(next_val),
            .o_val     (w_val[g]),
            .o_rd      (w_rd[g])
        );
    end

    // Only the addressed cell drives its value on a read; the rest drive zero.
    always_comb begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_bus = rd_bus | w_rd[i];
        end
    end

    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (cmd.del) begin
            n_count = r_count - CW'(1);
        end

        n_rd = '0;
        if (t_op'(i_opcode) == OP_READ) begin
            n_rd = in_range ? rd_bus : '1;
        end

        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd     <= n_rd;
            r_status <= n_status;
        end
    end

    assign o_valid         = r_valid;
    assign o_read_value    = r_rd;
    assign o_status        = r_status;
    assign o_element_count = COUNT_W'(r_count);

`ifndef SYNTH
    // The list never holds more elements than there are cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("element count exceeds capacity");

    // A full result is only reported while the list is full.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> full)
        else $error("full status with free cells");

    // An accepted head insert into a list with room grows the count by one.
    a_head_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == OP_INS_HEAD) && !full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("head insert did not grow the list");
`endif

endmodule
